>>> hdl/hds_pkg.sv
package hds_pkg;

	// field and arithmetic widths
	localparam int TEMP_BITS    = 24;
	localparam int GAIN_BITS    = 15;
	localparam int FRAC_BITS    = 16;
	localparam int LAP_BITS     = TEMP_BITS + 3;
	localparam int PROD_BITS    = LAP_BITS + GAIN_BITS + 1;
	localparam int NEXT_BITS    = PROD_BITS - FRAC_BITS + 1;
	localparam int SIDE_BITS    = 9;
	localparam int START_BITS   = 8;
	localparam int CNT_BITS     = 11;
	localparam int PADDR_BITS   = 5;
	localparam int PDATA_BITS   = 32;
	localparam int GRID_MAX_DEF = 256;

	localparam logic [TEMP_BITS-1:0] TEMP_MAX = {TEMP_BITS{1'b1}};

	// register reset values
	localparam logic [GAIN_BITS-1:0]  GAIN_RST     = 15'd8192;
	localparam logic [SIDE_BITS-1:0]  GRID_USE_RST = 9'd201;
	localparam logic [START_BITS-1:0] SRC_ROW_RST  = 8'd75;
	localparam logic [START_BITS-1:0] SRC_COL_RST  = 8'd75;
	localparam logic [SIDE_BITS-1:0]  SRC_SIDE_RST = 9'd50;

	// drain counter value in the last drain state, which carries the last stencil write
	localparam logic [1:0] DRAIN_LAST = 2'd2;

	typedef enum logic [2:0] {
		REG_GAIN     = 3'd0,
		REG_GRID_USE = 3'd1,
		REG_SRC_ROW  = 3'd2,
		REG_SRC_COL  = 3'd3,
		REG_SRC_SIDE = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_STEP  = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SWEEP,
		ST_DRAIN,
		ST_FILL,
		ST_FINISH
	} state_t;

endpackage

>>> hdl/hds_stencil.sv
module hds_stencil
	import hds_pkg::*;
#(
	parameter int ADDR_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [GAIN_BITS-1:0] gain,
	input  logic                 in_valid,
	input  logic [ADDR_BITS-1:0] in_addr,
	input  logic [TEMP_BITS-1:0] nb_up,
	input  logic [TEMP_BITS-1:0] nb_down,
	input  logic [TEMP_BITS-1:0] nb_left,
	input  logic [TEMP_BITS-1:0] nb_right,
	input  logic [TEMP_BITS-1:0] center,
	output logic                 wr_valid,
	output logic [ADDR_BITS-1:0] wr_addr,
	output logic [TEMP_BITS-1:0] wr_data
);

	logic                        valid_s2;
	logic                        valid_s3;
	logic [ADDR_BITS-1:0]        addr_s2;
	logic [ADDR_BITS-1:0]        addr_s3;
	logic [TEMP_BITS-1:0]        old_s2;
	logic [TEMP_BITS-1:0]        old_s3;
	logic signed [LAP_BITS-1:0]  lap_s2;
	logic signed [PROD_BITS-1:0] prod_s3;
	logic signed [LAP_BITS-1:0]  lap_sum;
	logic signed [NEXT_BITS-1:0] delta;
	logic signed [NEXT_BITS-1:0] next_val;

	// four-neighbor sum minus four times the center
	assign lap_sum = $signed(LAP_BITS'(nb_up)) + $signed(LAP_BITS'(nb_down))
		+ $signed(LAP_BITS'(nb_left)) + $signed(LAP_BITS'(nb_right))
		- $signed(LAP_BITS'({center, 2'b00}));

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= in_valid;
			valid_s3 <= valid_s2;
		end
	end

	// laplacian, then gain product
	always_ff @(posedge clk) begin
		lap_s2  <= lap_sum;
		old_s2  <= center;
		addr_s2 <= in_addr;
		prod_s3 <= PROD_BITS'(lap_s2) * $signed(PROD_BITS'({1'b0, gain}));
		old_s3  <= old_s2;
		addr_s3 <= addr_s2;
	end

	// floor scaling, add to old value, saturate
	assign delta    = NEXT_BITS'(prod_s3 >>> FRAC_BITS);
	assign next_val = delta + $signed(NEXT_BITS'(old_s3));

	always_comb begin
		if (next_val < 0) begin
			wr_data = '0;
		end else if (next_val > $signed(NEXT_BITS'(TEMP_MAX))) begin
			wr_data = TEMP_MAX;
		end else begin
			wr_data = next_val[TEMP_BITS-1:0];
		end
	end

	assign wr_valid = valid_s3;
	assign wr_addr  = addr_s3;

endmodule

>>> hdl/heat_diffusion_stencil_step_top.sv
// Explicit 2D heat-diffusion engine (five-point FTCS stencil) on a square grid of unsigned
// Q4.20 cells held in an internal memory. A command is taken when start is high and busy is
// low; each command gives exactly one result, shown for one cycle while done is high, and the
// receiver cannot stall it. Write cell, or an unknown command: result in the cycle after
// acceptance. Read cell: result registered from the read state that follows acceptance, zero
// for an address beyond the grid store. Step: for n of at least 3 the stencil sweeps rows 0 to
// n-2 of the in-use side n one cell per cycle (row 0 only loads the line buffer) and the
// drain states empty the stencil pipeline; then the clipped source square is written one cell
// per cycle, and the result is registered from the finish state that follows the last source
// cell. The grid memory has a single write port. Grid cells are undefined after reset and
// must be written before use.
module heat_diffusion_stencil_step_top
	import hds_pkg::*;
#(
	parameter int GRID_MAX = GRID_MAX_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// command channel
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            cmd,
	input  logic [7:0]            row,
	input  logic [7:0]            col,
	input  logic [TEMP_BITS-1:0]  cell_temp,
	input  logic [TEMP_BITS-1:0]  source_temp,
	// result channel
	output logic                  done,
	output logic [TEMP_BITS-1:0]  read_temp,
	output logic                  step_done,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [PDATA_BITS-1:0] pwdata,
	output logic [PDATA_BITS-1:0] prdata,
	output logic                  pready
);

	localparam int CB       = $clog2(GRID_MAX);
	localparam int IDX_BITS = 2 * CB;
	localparam int CELLS    = 2 ** IDX_BITS;

	// configuration registers
	logic [GAIN_BITS-1:0]  gain_q;
	logic [SIDE_BITS-1:0]  grid_use_q;
	logic [START_BITS-1:0] src_row_q;
	logic [START_BITS-1:0] src_col_q;
	logic [SIDE_BITS-1:0]  src_side_q;
	logic                  cfg_wr;
	reg_idx_t              cfg_idx;

	// control
	state_t               state_q;
	state_t               state_nx;
	logic                 accept;
	logic                 issue;
	logic                 fill_active;
	logic                 fill_we;
	logic                 host_we;
	logic                 sweep_last;
	logic                 in_store;
	logic                 in_store_q;
	logic [1:0]           drain_q;
	logic [CNT_BITS-1:0]  r_q;
	logic [CNT_BITS-1:0]  c_q;
	logic [CNT_BITS-1:0]  r_next;
	logic [CNT_BITS-1:0]  fr_q;
	logic [CNT_BITS-1:0]  fc_q;
	logic [CNT_BITS-1:0]  fc_next;
	logic [CNT_BITS-1:0]  n_side;
	logic [CNT_BITS-1:0]  row_end;
	logic [CNT_BITS-1:0]  col_end;
	logic [CNT_BITS-1:0]  lim_r;
	logic [CNT_BITS-1:0]  lim_c;
	logic [TEMP_BITS-1:0] src_q;

	// memories and read pipeline
	logic [TEMP_BITS-1:0] grid_mem [CELLS];
	logic [TEMP_BITS-1:0] line_mem [GRID_MAX];
	logic [IDX_BITS-1:0]  host_addr;
	logic [IDX_BITS-1:0]  rd_addr_a;
	logic [IDX_BITS-1:0]  rd_addr_b;
	logic [IDX_BITS-1:0]  wr_addr;
	logic [TEMP_BITS-1:0] wr_data;
	logic                 wr_en;
	logic [TEMP_BITS-1:0] rda_s1;
	logic [TEMP_BITS-1:0] rdb_s1;
	logic [TEMP_BITS-1:0] up_s1;
	logic                 valid_s1;
	logic [CNT_BITS-1:0]  row_s1;
	logic [CNT_BITS-1:0]  col_s1;
	logic [CNT_BITS-1:0]  col_m1;
	logic [TEMP_BITS-1:0] win0_q;
	logic [TEMP_BITS-1:0] win1_q;
	logic [TEMP_BITS-1:0] upw_q;
	logic [TEMP_BITS-1:0] dnw_q;
	logic                 st_in_valid;
	logic [IDX_BITS-1:0]  st_in_addr;
	logic                 st_wr_valid;
	logic [IDX_BITS-1:0]  st_wr_addr;
	logic [TEMP_BITS-1:0] st_wr_data;

	// result registers
	logic                 done_q;
	logic [TEMP_BITS-1:0] read_temp_q;
	logic                 step_done_q;

	// apb register file
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[PADDR_BITS-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q     <= GAIN_RST;
			grid_use_q <= GRID_USE_RST;
			src_row_q  <= SRC_ROW_RST;
			src_col_q  <= SRC_COL_RST;
			src_side_q <= SRC_SIDE_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_GAIN:     gain_q     <= pwdata[GAIN_BITS-1:0];
				REG_GRID_USE: grid_use_q <= pwdata[SIDE_BITS-1:0];
				REG_SRC_ROW:  src_row_q  <= pwdata[START_BITS-1:0];
				REG_SRC_COL:  src_col_q  <= pwdata[START_BITS-1:0];
				REG_SRC_SIDE: src_side_q <= pwdata[SIDE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_GAIN:     prdata = PDATA_BITS'(gain_q);
			REG_GRID_USE: prdata = PDATA_BITS'(grid_use_q);
			REG_SRC_ROW:  prdata = PDATA_BITS'(src_row_q);
			REG_SRC_COL:  prdata = PDATA_BITS'(src_col_q);
			REG_SRC_SIDE: prdata = PDATA_BITS'(src_side_q);
			default:      prdata = '0;
		endcase
	end

	// active side and clipped source bounds
	always_comb begin
		if (int'(grid_use_q) > GRID_MAX) begin
			n_side = CNT_BITS'(GRID_MAX);
		end else begin
			n_side = CNT_BITS'(grid_use_q);
		end
		row_end = CNT_BITS'(src_row_q) + CNT_BITS'(src_side_q);
		col_end = CNT_BITS'(src_col_q) + CNT_BITS'(src_side_q);
		lim_r   = (row_end > n_side) ? n_side : row_end;
		lim_c   = (col_end > n_side) ? n_side : col_end;
	end

	assign in_store    = (int'(row) < GRID_MAX) && (int'(col) < GRID_MAX);
	assign host_addr   = {CB'(row), CB'(col)};
	assign sweep_last  = (c_q == n_side - CNT_BITS'(1)) && (r_q == n_side - CNT_BITS'(2));
	assign fill_active = (fr_q < lim_r) && (fc_q < lim_c);
	assign r_next      = r_q + CNT_BITS'(1);
	assign fc_next     = fc_q + CNT_BITS'(1);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (cmd)
						CMD_READ: state_nx = ST_READ;
						CMD_STEP: state_nx = (n_side >= CNT_BITS'(3)) ? ST_SWEEP : ST_FILL;
						default:  state_nx = ST_IDLE;
					endcase
				end
			end
			ST_READ:   state_nx = ST_IDLE;
			ST_SWEEP:  state_nx = sweep_last ? ST_DRAIN : ST_SWEEP;
			ST_DRAIN:  state_nx = (drain_q == DRAIN_LAST) ? ST_FILL : ST_DRAIN;
			ST_FILL:   state_nx = fill_active ? ST_FILL : ST_FINISH;
			ST_FINISH: state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		busy    = (state_q != ST_IDLE);
		accept  = start && (state_q == ST_IDLE);
		issue   = (state_q == ST_SWEEP);
		fill_we = (state_q == ST_FILL) && fill_active;
		host_we = accept && (cmd == CMD_WRITE) && in_store;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// sweep, drain and fill counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q     <= '0;
			c_q     <= '0;
			fr_q    <= '0;
			fc_q    <= '0;
			drain_q <= '0;
		end else begin
			if (accept && (cmd == CMD_STEP)) begin
				r_q     <= '0;
				c_q     <= '0;
				fr_q    <= CNT_BITS'(src_row_q);
				fc_q    <= CNT_BITS'(src_col_q);
				drain_q <= '0;
			end
			if (issue) begin
				if (c_q == n_side - CNT_BITS'(1)) begin
					c_q <= '0;
					r_q <= sweep_last ? '0 : r_next;
				end else begin
					c_q <= c_q + CNT_BITS'(1);
				end
			end
			if (state_q == ST_DRAIN) begin
				drain_q <= drain_q + 2'd1;
			end
			if (fill_we) begin
				if (fc_next >= lim_c) begin
					fc_q <= CNT_BITS'(src_col_q);
					fr_q <= fr_q + CNT_BITS'(1);
				end else begin
					fc_q <= fc_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			src_q      <= source_temp;
			in_store_q <= in_store;
		end
	end

	// grid memory: one write port, two registered read ports
	assign rd_addr_a = issue ? {r_q[CB-1:0], c_q[CB-1:0]} : host_addr;
	assign rd_addr_b = {r_next[CB-1:0], c_q[CB-1:0]};

	always_comb begin
		if (st_wr_valid) begin
			wr_en   = 1'b1;
			wr_addr = st_wr_addr;
			wr_data = st_wr_data;
		end else if (fill_we) begin
			wr_en   = 1'b1;
			wr_addr = {fr_q[CB-1:0], fc_q[CB-1:0]};
			wr_data = src_q;
		end else begin
			wr_en   = host_we;
			wr_addr = host_addr;
			wr_data = cell_temp;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			grid_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rda_s1 <= grid_mem[rd_addr_a];
		rdb_s1 <= grid_mem[rd_addr_b];
	end

	// line buffer of pre-step values from the row above
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			line_mem[col_s1[CB-1:0]] <= rda_s1;
		end
	end

	always_ff @(posedge clk) begin
		up_s1 <= line_mem[c_q[CB-1:0]];
	end

	// read stage tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= r_q;
		col_s1 <= c_q;
	end

	// neighbor window: center and left lag the arriving column by one and two
	always_ff @(posedge clk) begin
		win0_q <= rda_s1;
		win1_q <= win0_q;
		upw_q  <= up_s1;
		dnw_q  <= rdb_s1;
	end

	// the cell one column back is interior once column 2 of its row arrives, on any row but row 0
	assign col_m1      = col_s1 - CNT_BITS'(1);
	assign st_in_valid = valid_s1 && (row_s1 != '0) && (col_s1 >= CNT_BITS'(2));
	assign st_in_addr  = {row_s1[CB-1:0], col_m1[CB-1:0]};

	hds_stencil #(
		.ADDR_BITS (IDX_BITS)
	) u_stencil (
		.clk      (clk),
		.arst_n   (arst_n),
		.gain     (gain_q),
		.in_valid (st_in_valid),
		.in_addr  (st_in_addr),
		.nb_up    (upw_q),
		.nb_down  (dnw_q),
		.nb_left  (win1_q),
		.nb_right (rda_s1),
		.center   (win0_q),
		.wr_valid (st_wr_valid),
		.wr_addr  (st_wr_addr),
		.wr_data  (st_wr_data)
	);

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (accept && (cmd != CMD_READ) && (cmd != CMD_STEP))
				|| (state_q == ST_READ) || (state_q == ST_FINISH);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			read_temp_q <= in_store_q ? rda_s1 : '0;
			step_done_q <= 1'b0;
		end else if (state_q == ST_FINISH) begin
			read_temp_q <= '0;
			step_done_q <= 1'b1;
		end else begin
			read_temp_q <= '0;
			step_done_q <= 1'b0;
		end
	end

	assign done      = done_q;
	assign read_temp = read_temp_q;
	assign step_done = step_done_q;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import hds_pkg::*;

	localparam logic [1:0] CMD_UNKNOWN = 2'd3;
	localparam int SIDE_MAX = 256;

	typedef struct packed {
		logic [TEMP_BITS-1:0] temp;
		logic                 stepped;
	} outcome_t;

	// dut ports
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [1:0]            cmd = '0;
	logic [7:0]            row = '0;
	logic [7:0]            col = '0;
	logic [TEMP_BITS-1:0]  cell_temp = '0;
	logic [TEMP_BITS-1:0]  source_temp = '0;
	logic                  done;
	logic [TEMP_BITS-1:0]  read_temp;
	logic                  step_done;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [PADDR_BITS-1:0] paddr = '0;
	logic [PDATA_BITS-1:0] pwdata = '0;
	logic [PDATA_BITS-1:0] prdata;
	logic                  pready;

	// grid image and register copies
	logic [TEMP_BITS-1:0]  grid_model [0:SIDE_MAX*SIDE_MAX-1];
	logic [TEMP_BITS-1:0]  prior_grid [0:SIDE_MAX*SIDE_MAX-1];
	bit                    written_map [0:SIDE_MAX*SIDE_MAX-1];
	logic [GAIN_BITS-1:0]  gain_cfg = GAIN_RST;
	logic [SIDE_BITS-1:0]  grid_use_cfg = GRID_USE_RST;
	logic [START_BITS-1:0] src_row_cfg = SRC_ROW_RST;
	logic [START_BITS-1:0] src_col_cfg = SRC_COL_RST;
	logic [SIDE_BITS-1:0]  src_side_cfg = SRC_SIDE_RST;

	outcome_t pending_outcomes [$];
	int       error_count = 0;
	bit       gaps_on = 1'b0;
	int       burst_left = 0;

	heat_diffusion_stencil_step_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.row         (row),
		.col         (col),
		.cell_temp   (cell_temp),
		.source_temp (source_temp),
		.done        (done),
		.read_temp   (read_temp),
		.step_done   (step_done),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#25_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// side of the grid that a step sweeps
	function automatic int active_side();
		return (grid_use_cfg > SIDE_MAX) ? SIDE_MAX : int'(grid_use_cfg);
	endfunction

	// one five-point update with floor scaling and saturation
	function automatic logic [TEMP_BITS-1:0] diffuse_cell(input logic [TEMP_BITS-1:0] mid,
			input logic [TEMP_BITS-1:0] nb_up, input logic [TEMP_BITS-1:0] nb_dn,
			input logic [TEMP_BITS-1:0] nb_lf, input logic [TEMP_BITS-1:0] nb_rt);
		longint lap;
		longint nxt;
		lap = longint'(nb_up) + longint'(nb_dn) + longint'(nb_lf) + longint'(nb_rt)
			- 4 * longint'(mid);
		nxt = longint'(mid) + ((lap * longint'(gain_cfg)) >>> FRAC_BITS);
		if (nxt < 0)
			return '0;
		else if (nxt > longint'(TEMP_MAX))
			return TEMP_MAX;
		else
			return nxt[TEMP_BITS-1:0];
	endfunction

	// jacobi sweep of the interior, then the clipped source square
	function automatic void advance_grid_model(input logic [TEMP_BITS-1:0] src);
		int n;
		int r;
		int c;
		int idx;
		int r_end;
		int c_end;
		n = active_side();
		for (r = 0; r < n; r++)
			for (c = 0; c < n; c++)
				prior_grid[r*SIDE_MAX+c] = grid_model[r*SIDE_MAX+c];
		for (r = 1; r < n - 1; r++) begin
			for (c = 1; c < n - 1; c++) begin
				idx = r*SIDE_MAX + c;
				grid_model[idx] = diffuse_cell(prior_grid[idx], prior_grid[idx-SIDE_MAX],
					prior_grid[idx+SIDE_MAX], prior_grid[idx-1], prior_grid[idx+1]);
			end
		end
		r_end = int'(src_row_cfg) + int'(src_side_cfg);
		c_end = int'(src_col_cfg) + int'(src_side_cfg);
		if (r_end > n) r_end = n;
		if (c_end > n) c_end = n;
		for (r = src_row_cfg; r < r_end; r++) begin
			for (c = src_col_cfg; c < c_end; c++) begin
				grid_model[r*SIDE_MAX+c] = src;
				written_map[r*SIDE_MAX+c] = 1'b1;
			end
		end
	endfunction

	// hold start low for some cycles
	task automatic pause(input int cycles);
		@(negedge clk);
		start = 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// stop sending until every result is in, then let the block settle
	task automatic wait_drained();
		pause(1);
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// send one item and record its expected result on acceptance
	task automatic send_item(input logic [1:0] op, input logic [7:0] r, input logic [7:0] c,
			input logic [TEMP_BITS-1:0] wtemp, input logic [TEMP_BITS-1:0] stemp);
		outcome_t exp_out;
		int       idx;
		if (gaps_on) begin
			if (burst_left == 0) begin
				pause($urandom_range(1, 6));
				burst_left = $urandom_range(1, 12);
			end
			burst_left--;
		end
		@(negedge clk);
		start = 1'b1;
		cmd = op;
		row = r;
		col = c;
		cell_temp = wtemp;
		source_temp = stemp;
		do @(posedge clk); while (busy);
		idx = int'(r)*SIDE_MAX + int'(c);
		exp_out = '0;
		case (op)
			CMD_WRITE: begin
				grid_model[idx] = wtemp;
				written_map[idx] = 1'b1;
			end
			CMD_STEP: begin
				advance_grid_model(stemp);
				exp_out.stepped = 1'b1;
			end
			CMD_READ: begin
				exp_out.temp = grid_model[idx];
			end
			default: ;
		endcase
		pending_outcomes.push_back(exp_out);
	endtask

	// register write over apb, then read back
	task automatic set_reg(input reg_idx_t idx, input logic [31:0] val);
		logic [31:0] held;
		logic [31:0] got;
		wait_drained();
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_GAIN:     gain_cfg = val[GAIN_BITS-1:0];
			REG_GRID_USE: grid_use_cfg = val[SIDE_BITS-1:0];
			REG_SRC_ROW:  src_row_cfg = val[START_BITS-1:0];
			REG_SRC_COL:  src_col_cfg = val[START_BITS-1:0];
			REG_SRC_SIDE: src_side_cfg = val[SIDE_BITS-1:0];
			default: ;
		endcase
		case (idx)
			REG_GAIN:     held = 32'(gain_cfg);
			REG_GRID_USE: held = 32'(grid_use_cfg);
			REG_SRC_ROW:  held = 32'(src_row_cfg);
			REG_SRC_COL:  held = 32'(src_col_cfg);
			default:      held = 32'(src_side_cfg);
		endcase
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		if (got !== held) begin
			$display("%0t: register %s readback, expected %h, actual %h",
				$time, idx.name(), held, got);
			error_count++;
		end
	endtask

	// write every cell of the swept grid that holds no value yet
	task automatic fill_active_grid();
		int n;
		int r;
		int c;
		n = active_side();
		for (r = 0; r < n; r++)
			for (c = 0; c < n; c++)
				if (!written_map[r*SIDE_MAX+c])
					send_item(CMD_WRITE, 8'(r), 8'(c), TEMP_BITS'($urandom),
						TEMP_BITS'($urandom));
	endtask

	// result checker
	always @(posedge clk) begin
		outcome_t exp_out;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t: result with no item pending, actual read_temp %h step_done %b",
					$time, read_temp, step_done);
				error_count++;
			end else begin
				exp_out = pending_outcomes.pop_front();
				if (read_temp !== exp_out.temp) begin
					$display("%0t: read_temp mismatch, expected %h, actual %h",
						$time, exp_out.temp, read_temp);
					error_count++;
				end
				if (step_done !== exp_out.stepped) begin
					$display("%0t: step_done mismatch, expected %b, actual %b",
						$time, exp_out.stepped, step_done);
					error_count++;
				end
			end
		end
	end

	// far corners of the store with the whole store in use, and an unknown command
	task automatic test_cell_access();
		set_reg(REG_GRID_USE, 32'd256);
		send_item(CMD_WRITE, 8'd255, 8'd255, TEMP_MAX, '0);
		send_item(CMD_WRITE, 8'd255, 8'd0, '0, TEMP_MAX);
		send_item(CMD_UNKNOWN, 8'($urandom), 8'($urandom), TEMP_BITS'($urandom),
			TEMP_BITS'($urandom));
		send_item(CMD_READ, 8'd255, 8'd255, TEMP_BITS'($urandom), TEMP_BITS'($urandom));
		send_item(CMD_READ, 8'd255, 8'd0, TEMP_BITS'($urandom), TEMP_BITS'($urandom));
	endtask

	// saturation both ways and floor of a negative product on a 3x3 grid
	task automatic test_stencil_limits();
		int r;
		int c;
		set_reg(REG_GRID_USE, 32'd3);
		set_reg(REG_SRC_SIDE, 32'd0);
		set_reg(REG_GAIN, 32'd32767);
		// hot border around a cold center
		for (r = 0; r < 3; r++)
			for (c = 0; c < 3; c++)
				send_item(CMD_WRITE, 8'(r), 8'(c), (r == 1 && c == 1) ? '0 : TEMP_MAX, '0);
		send_item(CMD_STEP, '0, '0, '0, TEMP_MAX);
		send_item(CMD_READ, 8'd1, 8'd1, '0, '0);
		// hot center, cold neighbors
		send_item(CMD_WRITE, 8'd0, 8'd1, '0, '0);
		send_item(CMD_WRITE, 8'd2, 8'd1, '0, '0);
		send_item(CMD_WRITE, 8'd1, 8'd0, '0, '0);
		send_item(CMD_WRITE, 8'd1, 8'd2, '0, '0);
		send_item(CMD_STEP, '0, '0, '0, '0);
		send_item(CMD_READ, 8'd1, 8'd1, '0, '0);
		// tiny negative laplacian rounds down
		set_reg(REG_GAIN, 32'd1);
		send_item(CMD_WRITE, 8'd1, 8'd1, 24'd1, '0);
		send_item(CMD_STEP, '0, '0, '0, '0);
		send_item(CMD_READ, 8'd1, 8'd1, '0, '0);
		send_item(CMD_READ, 8'd0, 8'd0, '0, '0);
	endtask

	// grids without interior only apply the clipped source square
	task automatic test_tiny_grid();
		set_reg(REG_SRC_ROW, 32'd0);
		set_reg(REG_SRC_COL, 32'd0);
		set_reg(REG_SRC_SIDE, 32'd511);
		set_reg(REG_GRID_USE, 32'd2);
		send_item(CMD_STEP, '0, '0, '0, TEMP_MAX);
		send_item(CMD_READ, 8'd1, 8'd1, '0, '0);
		set_reg(REG_GRID_USE, 32'd1);
		send_item(CMD_STEP, '0, '0, '0, '0);
		send_item(CMD_READ, 8'd0, 8'd0, '0, '0);
		send_item(CMD_READ, 8'd1, 8'd1, '0, '0);
		set_reg(REG_GRID_USE, 32'd0);
		send_item(CMD_STEP, '0, '0, '0, TEMP_BITS'($urandom));
		send_item(CMD_READ, 8'd0, 8'd0, '0, '0);
	endtask

	// random mix of writes, reads, steps and unknown commands over small grids
	task automatic test_random_traffic();
		int items;
		int phase;
		int ops;
		int k;
		int n;
		int roll;
		logic [7:0] r;
		logic [7:0] c;
		items = 0;
		phase = 0;
		while (items < 50) begin
			gaps_on = (phase != 0);
			case (phase % 5)
				1: set_reg(REG_GAIN, 32'd16384);
				2: set_reg(REG_GAIN, 32'd0);
				default: set_reg(REG_GAIN, $urandom_range(0, 16384));
			endcase
			set_reg(REG_GRID_USE, $urandom_range(3, 6));
			set_reg(REG_SRC_ROW, (phase == 1) ? 32'd255 : $urandom_range(0, 8));
			set_reg(REG_SRC_COL, (phase == 2) ? 32'd255 : $urandom_range(0, 8));
			set_reg(REG_SRC_SIDE, (phase == 3) ? 32'd256 : $urandom_range(0, 5));
			fill_active_grid();
			n = active_side();
			ops = $urandom_range(15, 25);
			for (k = 0; k < ops; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 40) begin
					// writes mostly land on the swept grid
					if ($urandom_range(0, 9) < 7) begin
						r = 8'($urandom_range(0, n - 1));
						c = 8'($urandom_range(0, n - 1));
					end else begin
						r = 8'($urandom);
						c = 8'($urandom);
					end
					send_item(CMD_WRITE, r, c, TEMP_BITS'($urandom), TEMP_BITS'($urandom));
					items++;
				end else if (roll < 72) begin
					// reads only touch cells that hold a value
					r = 8'($urandom);
					c = 8'($urandom);
					if (!written_map[int'(r)*SIDE_MAX+int'(c)]) begin
						r = 8'($urandom_range(0, n - 1));
						c = 8'($urandom_range(0, n - 1));
					end
					send_item(CMD_READ, r, c, TEMP_BITS'($urandom), TEMP_BITS'($urandom));
					items++;
				end else if (roll < 90) begin
					send_item(CMD_STEP, 8'($urandom), 8'($urandom), TEMP_BITS'($urandom),
						TEMP_BITS'($urandom));
					items++;
				end else if (roll < 95) begin
					send_item(CMD_UNKNOWN, 8'($urandom), 8'($urandom), TEMP_BITS'($urandom),
						TEMP_BITS'($urandom));
					items++;
				end else begin
					wait_drained();
				end
			end
			phase++;
		end
		gaps_on = 1'b0;
	endtask

	// oversized grid setting held as written, cells across the whole store
	task automatic test_full_grid();
		int k;
		logic [7:0] r;
		logic [7:0] c;
		set_reg(REG_GRID_USE, 32'd511);
		set_reg(REG_GAIN, 32'd16384);
		set_reg(REG_SRC_ROW, 32'd200);
		set_reg(REG_SRC_COL, 32'd10);
		set_reg(REG_SRC_SIDE, 32'd256);
		send_item(CMD_WRITE, 8'd0, 8'd0, TEMP_BITS'($urandom), '0);
		send_item(CMD_WRITE, 8'd0, 8'd255, TEMP_BITS'($urandom), '0);
		send_item(CMD_READ, 8'd0, 8'd0, '0, '0);
		send_item(CMD_READ, 8'd0, 8'd255, '0, '0);
		send_item(CMD_READ, 8'd255, 8'd255, '0, '0);
		for (k = 0; k < 6; k++) begin
			r = 8'($urandom);
			c = 8'($urandom);
			send_item(CMD_WRITE, r, c, TEMP_BITS'($urandom), TEMP_BITS'($urandom));
			send_item(CMD_READ, r, c, TEMP_BITS'($urandom), TEMP_BITS'($urandom));
		end
	endtask

	// main sequence
	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_cell_access();
		test_stencil_limits();
		test_tiny_grid();
		test_random_traffic();
		test_full_grid();
		pause(1);
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
